/* rtl/efr_pkg.sv */
package efr_pkg;

	localparam int MaxPayloadDefault = 32;
	localparam logic [7:0] CrcPoly = 8'h8C;

	typedef enum logic [2:0] {
		PH_WAIT = 3'd0,
		PH_CRC  = 3'd1,
		PH_LEN  = 3'd2,
		PH_DATA = 3'd3,
		PH_ESC  = 3'd4,
		PH_END  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ST_GOOD      = 3'd0,
		ST_LEN_ERR   = 3'd1,
		ST_CRC_ERR   = 3'd2,
		ST_FRAME_ERR = 3'd3,
		ST_TIMEOUT   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		REG_ENABLE  = 3'd0,
		REG_START   = 3'd1,
		REG_END     = 3'd2,
		REG_ESCAPE  = 3'd3,
		REG_TIMEOUT = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CHECK,
		BK_EMIT
	} bk_state_t;

	// front-to-back command: an error or a frame to check
	typedef struct packed {
		logic       is_frame;
		status_t    status;
		logic [7:0] length;
		logic [7:0] crc;
	} cmd_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] d);
		logic [7:0] c;
		logic [7:0] v;
		c = crc;
		v = d;
		for (int b = 0; b < 8; b++) begin
			if ((c[0] ^ v[0]) == 1'b1) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
			v = v >> 1;
		end
		return c;
	endfunction

endpackage

/* rtl/efr_front.sv */
module efr_front #(
	parameter int MAX_PAYLOAD = efr_pkg::MaxPayloadDefault,
	parameter int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_kind,
	input  logic [7:0]        in_byte,
	input  logic              en,
	input  logic [7:0]        start_code,
	input  logic [7:0]        end_code,
	input  logic [7:0]        escape_code,
	input  logic [15:0]       timeout_ticks,
	input  logic              back_busy,
	output logic              wr_en,
	output logic [AW-1:0]     wr_addr,
	output logic [7:0]        wr_data,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output efr_pkg::cmd_t     cmd
);
	import efr_pkg::*;

	localparam logic [8:0] MaxLen = 9'(MAX_PAYLOAD);

	phase_t      phase_q;
	logic [7:0]  crc_q;
	logic [7:0]  len_q;
	logic [6:0]  pos_q;
	logic [15:0] idle_q;
	logic        cmd_valid_q;
	cmd_t        cmd_q;

	logic        acc;
	logic [15:0] idle_inc;
	logic [15:0] limit;
	logic        store;

	// hold input while a command waits or the back end reads the payload memory
	assign in_ready  = !cmd_valid_q && !back_busy;
	assign acc       = in_valid && in_ready;
	assign idle_inc  = idle_q + 16'd1;
	assign limit     = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
	assign cmd_valid = cmd_valid_q;
	assign cmd       = cmd_q;

	always_comb begin
		store = 1'b0;
		if (acc && en && !in_kind) begin
			if (phase_q == PH_ESC) begin
				store = 1'b1;
			end else if (phase_q == PH_DATA && in_byte != escape_code &&
				in_byte != end_code && in_byte != start_code) begin
				store = 1'b1;
			end
		end
	end

	assign wr_en   = store && (pos_q < 7'(MAX_PAYLOAD));
	assign wr_addr = pos_q[AW-1:0];
	assign wr_data = in_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT;
			crc_q       <= 8'd0;
			len_q       <= 8'd0;
			pos_q       <= 7'd0;
			idle_q      <= 16'd0;
			cmd_valid_q <= 1'b0;
			cmd_q       <= '0;
		end else begin
			if (cmd_valid_q && cmd_ready) begin
				cmd_valid_q <= 1'b0;
			end
			if (acc) begin
				if (!en) begin
					phase_q <= PH_WAIT;
					idle_q  <= 16'd0;
				end else if (in_kind) begin
					if (phase_q != PH_WAIT) begin
						idle_q <= idle_inc;
						if (idle_inc >= limit) begin
							phase_q     <= PH_WAIT;
							idle_q      <= 16'd0;
							cmd_valid_q <= 1'b1;
							cmd_q       <= '{1'b0, ST_TIMEOUT, len_q, crc_q};
						end
					end
				end else begin
					idle_q <= 16'd0;
					case (phase_q)
						PH_CRC: begin
							crc_q   <= in_byte;
							phase_q <= PH_LEN;
						end
						PH_LEN: begin
							len_q <= in_byte;
							if (in_byte == 8'd0 || {1'b0, in_byte} > MaxLen) begin
								phase_q     <= PH_WAIT;
								cmd_valid_q <= 1'b1;
								cmd_q       <= '{1'b0, ST_LEN_ERR, in_byte, crc_q};
							end else begin
								pos_q   <= 7'd0;
								phase_q <= PH_DATA;
							end
						end
						PH_DATA, PH_ESC: begin
							if (phase_q == PH_DATA && in_byte == escape_code) begin
								phase_q <= PH_ESC;
							end else if (phase_q == PH_DATA &&
								(in_byte == end_code || in_byte == start_code)) begin
								phase_q     <= PH_WAIT;
								cmd_valid_q <= 1'b1;
								cmd_q       <= '{1'b0, ST_LEN_ERR, len_q, crc_q};
							end else begin
								pos_q <= pos_q + 7'd1;
								if ({1'b0, pos_q} + 8'd1 >= len_q) begin
									phase_q <= PH_END;
								end else begin
									phase_q <= PH_DATA;
								end
							end
						end
						PH_END: begin
							phase_q     <= PH_WAIT;
							cmd_valid_q <= 1'b1;
							if (in_byte != end_code) begin
								cmd_q <= '{1'b0, ST_FRAME_ERR, len_q, crc_q};
							end else begin
								cmd_q <= '{1'b1, ST_GOOD, len_q, crc_q};
							end
						end
						default: begin
							if (in_byte == start_code) begin
								len_q   <= 8'd0;
								crc_q   <= 8'd0;
								pos_q   <= 7'd0;
								phase_q <= PH_CRC;
							end
						end
					endcase
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid_q && !cmd_ready |=> cmd_valid_q && $stable(cmd_q))
		else $error("command dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> phase_q == PH_DATA || phase_q == PH_ESC)
		else $error("store write outside payload");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid_q |-> !in_ready)
		else $error("input taken while command pending");

endmodule

/* rtl/efr_back.sv */
module efr_back #(
	parameter int MAX_PAYLOAD = efr_pkg::MaxPayloadDefault,
	parameter int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  efr_pkg::cmd_t cmd,
	output logic          busy,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [2:0]    status,
	output logic [7:0]    payload_byte,
	output logic [7:0]    packet_length,
	output logic          last
);
	import efr_pkg::*;

	logic [7:0] mem [MAX_PAYLOAD];
	logic [7:0] rd_q;

	bk_state_t  st_q, st_d;
	cmd_t       cmd_q;
	logic [6:0] rd_pos_q;
	logic       rd_live_q;
	logic [7:0] crc_q;
	logic       out_valid_q;
	logic [2:0] status_q;
	logic [7:0] byte_q;
	logic [7:0] len_q;
	logic       last_q;

	logic       slot_free;
	logic       take_cmd;
	logic [7:0] n_len;
	logic       rd_issue;
	logic       rd_done;
	logic [7:0] crc_next;

	assign slot_free = !out_valid_q || out_ready;
	assign n_len     = cmd_q.length;
	assign crc_next  = crc8_byte(crc_q, rd_q);
	assign busy      = (st_q != BK_IDLE);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_pos_q[AW-1:0]];
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE: if (cmd_valid && slot_free) begin
				st_d = cmd.is_frame ? BK_CHECK : BK_IDLE;
			end
			BK_CHECK: if (rd_done) begin
				st_d = (crc_next == cmd_q.crc) ? BK_EMIT : BK_IDLE;
			end
			BK_EMIT: if (rd_done) begin
				st_d = BK_IDLE;
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_comb begin
		take_cmd  = 1'b0;
		rd_issue  = 1'b0;
		cmd_ready = 1'b0;
		unique case (st_q)
			BK_IDLE: begin
				cmd_ready = slot_free;
				take_cmd  = cmd_valid && slot_free;
			end
			BK_CHECK: rd_issue = !rd_live_q && ({1'b0, rd_pos_q} < n_len);
			BK_EMIT:  rd_issue = !rd_live_q && slot_free && ({1'b0, rd_pos_q} < n_len);
			default: ;
		endcase
	end

	assign rd_done = rd_live_q && ({1'b0, rd_pos_q} == n_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BK_IDLE;
			cmd_q       <= '0;
			rd_pos_q    <= 7'd0;
			rd_live_q   <= 1'b0;
			crc_q       <= 8'd0;
			out_valid_q <= 1'b0;
			status_q    <= 3'd0;
			byte_q      <= 8'd0;
			len_q       <= 8'd0;
			last_q      <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			rd_live_q <= rd_issue;
			if (rd_issue) begin
				rd_pos_q <= rd_pos_q + 7'd1;
			end
			if (take_cmd) begin
				cmd_q    <= cmd;
				rd_pos_q <= 7'd0;
				crc_q    <= 8'd0;
				if (!cmd.is_frame) begin
					out_valid_q <= 1'b1;
					status_q    <= cmd.status;
					byte_q      <= 8'd0;
					len_q       <= cmd.length;
					last_q      <= 1'b1;
				end
			end
			if (st_q == BK_CHECK && rd_live_q) begin
				crc_q <= crc_next;
				if (rd_done) begin
					rd_pos_q <= 7'd0;
					if (crc_next != cmd_q.crc) begin
						out_valid_q <= 1'b1;
						status_q    <= ST_CRC_ERR;
						byte_q      <= 8'd0;
						len_q       <= cmd_q.length;
						last_q      <= 1'b1;
					end
				end
			end
			if (st_q == BK_EMIT && rd_live_q) begin
				out_valid_q <= 1'b1;
				status_q    <= ST_GOOD;
				byte_q      <= rd_q;
				len_q       <= cmd_q.length;
				last_q      <= rd_done;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign payload_byte  = byte_q;
	assign packet_length = len_q;
	assign last          = last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		rd_live_q && st_q == BK_EMIT |-> slot_free)
		else $error("payload read with no output slot");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_GOOD |-> last_q && byte_q == 8'd0)
		else $error("error result malformed");
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q != BK_IDLE |-> cmd_q.is_frame)
		else $error("non-frame command in check");

endmodule

/* rtl/escaped_frame_receiver_crc8_top.sv */
// channel | dir | handshake              | content
// s_axis  | in  | s_axis_tvalid/tready   | tdata[7:0] rx_byte, tuser item_kind
// m_axis  | out | m_axis_tvalid/tready   | tdata payload_byte,packet_length; tuser status; tlast
// cfg     | in  | cfg_valid/cfg_ready    | cfg_index register, cfg_data value
// The front handles each byte or tick as it is accepted; input holds off while a command waits
// for the back or the back works on a frame.
// The back reads the payload memory twice for a good frame (one CRC pass, one emit pass),
// issuing each byte read only after the previous one has returned; a command that reports an error needs no read.
// Reset clears all control state; the payload memory is not cleared.
// Output stalls back up through the one-entry command register into s_axis_tready.
module escaped_frame_receiver_crc8_top #(
	parameter int MAX_PAYLOAD = efr_pkg::MaxPayloadDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	input  logic        s_axis_tuser,  // [0] item_kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [7:0] payload_byte, [15:8] packet_length
	output logic [2:0]  m_axis_tuser,  // [2:0] status
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import efr_pkg::*;

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	logic        en_q;
	logic [7:0]  start_q, end_q, esc_q;
	logic [15:0] tmo_q;
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]  wr_data;
	logic        cmd_valid, cmd_ready;
	cmd_t        cmd;
	logic        back_busy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q    <= 1'b0;
			start_q <= 8'd2;
			end_q   <= 8'd3;
			esc_q   <= 8'd27;
			tmo_q   <= 16'd1000;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ENABLE:  en_q    <= cfg_data[0];
				REG_START:   start_q <= cfg_data[7:0];
				REG_END:     end_q   <= cfg_data[7:0];
				REG_ESCAPE:  esc_q   <= cfg_data[7:0];
				REG_TIMEOUT: tmo_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	efr_front #(.MAX_PAYLOAD(MAX_PAYLOAD), .AW(AW)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_kind(s_axis_tuser), .in_byte(s_axis_tdata),
		.en(en_q), .start_code(start_q), .end_code(end_q),
		.escape_code(esc_q), .timeout_ticks(tmo_q),
		.back_busy,
		.wr_en, .wr_addr, .wr_data,
		.cmd_valid, .cmd_ready, .cmd
	);

	efr_back #(.MAX_PAYLOAD(MAX_PAYLOAD), .AW(AW)) u_back (
		.clk, .arst_n,
		.wr_en, .wr_addr, .wr_data,
		.cmd_valid, .cmd_ready, .cmd,
		.busy(back_busy),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.status(m_axis_tuser), .payload_byte(m_axis_tdata[7:0]),
		.packet_length(m_axis_tdata[15:8]), .last(m_axis_tlast)
	);

endmodule
